>>> src/sal_pkg.sv
// ----------------------------------------------------------------------------
// Shifting array list package
// Shared widths, request and status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int IDX_W     = 8;
	localparam int VAL_W     = 32;
	localparam int LEN_W     = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		K_READ      = 3'd0,
		K_INS_FRONT = 3'd1,
		K_INS_BACK  = 3'd2,
		K_REM_FRONT = 3'd3,
		K_REM_BACK  = 3'd4,
		K_INS_AT    = 3'd5,
		K_REM_AT    = 3'd6,
		K_RESIZE    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// What every cell of the chain does at a clock edge.
	typedef enum logic [1:0] {
		CM_HOLD   = 2'd0,
		CM_INSERT = 2'd1,
		CM_REMOVE = 2'd2,
		CM_ROTATE = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t       mode;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] tap;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_GROW = 2'd2
	} state_t;

endpackage

>>> src/sal_cell.sv
// ----------------------------------------------------------------------------
// Shifting array list cell
// One list entry; takes its lower or upper neighbor's value on a shift, or the new value at the insert position.
// ----------------------------------------------------------------------------
module sal_cell #(
	parameter int K = 0
) (
	input  logic                       clk,
	input  sal_pkg::cell_cmd_t         cmd,
	input  logic [sal_pkg::VAL_W-1:0]  ins,
	input  logic [sal_pkg::VAL_W-1:0]  lower,
	input  logic [sal_pkg::VAL_W-1:0]  upper,
	output logic [sal_pkg::VAL_W-1:0]  data,
	output logic [sal_pkg::VAL_W-1:0]  tap_val
);
	import sal_pkg::*;

	localparam logic [IDX_W-1:0] KEY = IDX_W'(K);

	logic [VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (cmd.mode)
			CM_HOLD: begin
				data_q <= data_q;
			end
			CM_INSERT: begin
				if (KEY > cmd.pos) begin
					data_q <= lower;
				end else if (KEY == cmd.pos) begin
					data_q <= ins;
				end
			end
			CM_REMOVE: begin
				if (KEY >= cmd.pos) begin
					data_q <= upper;
				end
			end
			CM_ROTATE: begin
				data_q <= lower;
			end
		endcase
	end

	assign data    = data_q;
	assign tap_val = (cmd.tap == KEY) ? data_q : '0;

endmodule

>>> src/sal_rem.sv
// ----------------------------------------------------------------------------
// Shifting array list remainder unit
// Restoring division of an index by the list length, one bit per cycle.
// ----------------------------------------------------------------------------
module sal_rem #(
	parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sal_pkg::IDX_W-1:0]           dividend,
	input  logic [$clog2(DEPTH+1)-1:0]          divisor,
	output logic                                done,
	output logic [$clog2(DEPTH+1)-1:0]          remainder
);
	import sal_pkg::*;

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CNT_W = $clog2(IDX_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] num_q;
	logic [CW-1:0]    rem_q;
	logic [CW:0]      trial;
	logic [CW:0]      div_x;
	logic [CW-1:0]    rem_next;
	logic             last;

	// The partial remainder stays below the divisor, so the trial stays below twice it.
	always_comb begin
		trial    = {rem_q, num_q[IDX_W-1]};
		div_x    = {1'b0, divisor};
		rem_next = (trial >= div_x) ? CW'(trial - div_x) : trial[CW-1:0];
		last     = (cnt_q == CNT_W'(IDX_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[IDX_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> src/shifting_array_list.sv
// ----------------------------------------------------------------------------
// Shifting array list
// Ordered list of signed 32-bit values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   --------  --------------------  ------------------------------------
//   request   req_valid, req_stall  kind, index, value
//   response  rsp_valid, rsp_stall  read_value, length, status
//
// Inserts, removals, shrinking resizes and refused requests finish in the
// cycle of the request transfer; the cell chain shifts all entries past the position at once.
// A read of a non-empty list first runs the bit-serial remainder unit that
// folds the index into the length, then picks the cell through the tap.
// A growing resize from length c to n rotates the first c entries as a ring
// a whole number of turns, until every cell below n holds one of them.
// Reset clears the length and the controller; entry contents are undefined
// until written, with no clearing pass. One request is in work at a time,
// and a new request transfer also waits while a response sits stalled in the output register.
module shifting_array_list #(
	parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [2:0]                         kind,
	input  logic [sal_pkg::IDX_W-1:0]          index,
	input  logic signed [sal_pkg::VAL_W-1:0]   value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic signed [sal_pkg::VAL_W-1:0]   read_value,
	output logic [sal_pkg::LEN_W-1:0]          length,
	output logic [1:0]                         status
);
	import sal_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > IDX_W) ? CW : IDX_W) + 1;

	// Controller state.
	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] n_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] phase_q;
	logic [CW-1:0] step_next;
	logic [CW-1:0] phase_next;
	logic          grow_last;

	// Response register.
	logic             rsp_valid_q;
	logic [VAL_W-1:0] read_value_q;
	logic [LEN_W-1:0] length_q;
	status_t          status_q;

	// Decoded request.
	logic             req_accept;
	logic             load_rsp;
	logic             go_read;
	logic             go_grow;
	status_t          st_d;
	logic [VAL_W-1:0] rd_d;
	cell_cmd_t        cmd;

	// Comparisons between the index and the length at a common width.
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] idx_x;
	logic [CMPW-1:0] dep_x;
	logic            full;
	logic            empty;

	// Remainder unit.
	logic          rem_start;
	logic          rem_done;
	logic [CW-1:0] rem;

	// Cell chain.
	logic [VAL_W-1:0] cell_val [DEPTH];
	logic [VAL_W-1:0] tap_val  [DEPTH];
	logic [VAL_W-1:0] tap_bus;

	assign req_stall  = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_accept = req_valid && !req_stall;

	always_comb begin
		cnt_x = CMPW'(count_q);
		idx_x = CMPW'(index);
		dep_x = CMPW'(DEPTH);
		full  = (cnt_x == dep_x);
		empty = (count_q == '0);
	end

	// A growing resize rotates the first count entries as a ring while the
	// whole chain shifts up, so after t steps cell m below count + t holds old
	// entry (m - t) mod count. It stops on a whole number of turns once every cell
	// below the new length has been reached.
	always_comb begin
		step_next  = step_q + CW'(1);
		phase_next = (phase_q + CW'(1) == count_q) ? '0 : phase_q + CW'(1);
		grow_last  = (phase_next == '0) && (step_next >= n_q - count_q);
	end

	// Output decode: cell command, new length, status and response load.
	always_comb begin
		cmd.mode  = CM_HOLD;
		cmd.pos   = index;
		cmd.tap   = '0;
		count_d   = count_q;
		st_d      = ST_OK;
		rd_d      = '0;
		load_rsp  = 1'b0;
		go_read   = 1'b0;
		go_grow   = 1'b0;
		rem_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					unique case (kind_t'(kind))
						K_READ: begin
							if (empty) begin
								st_d     = ST_EMPTY;
								load_rsp = 1'b1;
							end else begin
								rem_start = 1'b1;
								go_read   = 1'b1;
							end
						end
						K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
							load_rsp = 1'b1;
							priority if (full) begin
								st_d = ST_FULL;
							end else if (kind_t'(kind) == K_INS_AT && idx_x > cnt_x) begin
								st_d = ST_RANGE;
							end else begin
								cmd.mode = CM_INSERT;
								if (kind_t'(kind) == K_INS_FRONT) begin
									cmd.pos = '0;
								end else if (kind_t'(kind) == K_INS_BACK) begin
									cmd.pos = IDX_W'(count_q);
								end
								count_d = count_q + CW'(1);
							end
						end
						K_REM_FRONT, K_REM_BACK, K_REM_AT: begin
							load_rsp = 1'b1;
							priority if (empty) begin
								st_d = ST_EMPTY;
							end else if (kind_t'(kind) == K_REM_AT && idx_x >= cnt_x) begin
								st_d = ST_RANGE;
							end else begin
								cmd.mode = CM_REMOVE;
								if (kind_t'(kind) == K_REM_FRONT) begin
									cmd.pos = '0;
								end else if (kind_t'(kind) == K_REM_BACK) begin
									cmd.pos = IDX_W'(count_q - CW'(1));
								end
								count_d = count_q - CW'(1);
							end
						end
						K_RESIZE: begin
							priority if (idx_x > dep_x) begin
								st_d     = ST_RANGE;
								load_rsp = 1'b1;
							end else if (index == '0) begin
								count_d  = '0;
								load_rsp = 1'b1;
							end else if (empty) begin
								st_d     = ST_EMPTY;
								load_rsp = 1'b1;
							end else if (idx_x <= cnt_x) begin
								// Shrinking keeps the leading entries as they are.
								count_d  = CW'(index);
								load_rsp = 1'b1;
							end else begin
								go_grow = 1'b1;
							end
						end
					endcase
				end
			end
			S_READ: begin
				cmd.tap = IDX_W'(rem);
				if (rem_done) begin
					rd_d     = tap_bus;
					load_rsp = 1'b1;
				end
			end
			S_GROW: begin
				// The ring closes through the tap: cell 0 takes the last entry.
				cmd.mode = CM_ROTATE;
				cmd.tap  = IDX_W'(count_q - CW'(1));
				if (grow_last) begin
					count_d  = n_q;
					load_rsp = 1'b1;
				end
			end
			default: begin
				cmd.mode = CM_HOLD;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (go_read) begin
					state_d = S_READ;
				end else if (go_grow) begin
					state_d = S_GROW;
				end
			end
			S_READ: begin
				if (rem_done) begin
					state_d = S_IDLE;
				end
			end
			S_GROW: begin
				if (grow_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_grow) begin
			n_q     <= CW'(index);
			step_q  <= '0;
			phase_q <= '0;
		end else if (state_q == S_GROW) begin
			step_q  <= step_next;
			phase_q <= phase_next;
		end
		if (load_rsp) begin
			read_value_q <= rd_d;
			length_q     <= LEN_W'(count_d);
			status_q     <= st_d;
		end
	end

	sal_rem #(
		.DEPTH(DEPTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (index),
		.divisor  (count_q),
		.done     (rem_done),
		.remainder(rem)
	);

	// The chain: each cell sees both neighbors, cell 0 sees the tap below it.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [VAL_W-1:0] lower;
		logic [VAL_W-1:0] upper;

		if (k == 0) begin : g_first
			assign lower = tap_bus;
		end else begin : g_mid_lo
			assign lower = cell_val[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = cell_val[k+1];
		end

		sal_cell #(
			.K(k)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.ins    (value),
			.lower  (lower),
			.upper  (upper),
			.data   (cell_val[k]),
			.tap_val(tap_val[k])
		);
	end

	// Only the addressed cell drives a nonzero tap value.
	always_comb begin
		tap_bus = '0;
		for (int k = 0; k < DEPTH; k++) begin
			tap_bus = tap_bus | tap_val[k];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign length     = length_q;
	assign status     = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= dep_x)
		else $error("list length exceeds the depth");

	a_busy_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ || state_q == S_GROW) |-> !rsp_valid_q)
		else $error("response pending while a request is in work");

	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(load_rsp && st_d != ST_OK) |=> count_q == $past(count_q))
		else $error("refused request changed the length");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GROW |-> (phase_q < count_q && n_q > count_q))
		else $error("resize rotation out of range");
`endif

endmodule
